### src/rgbh_pkg.sv
// shared types, constants and control codes of the rgb to hue pipeline
package rgbh_pkg;

	localparam int CHAN_BITS = 8;
	localparam int NUM_CH    = 3;
	localparam int SCALE     = 60;
	localparam int DVD_BITS  = CHAN_BITS + $clog2(SCALE);
	localparam int HUE_BITS  = 9;

	// lane order inside the channel vectors
	localparam int CH_R = 0;
	localparam int CH_G = 1;
	localparam int CH_B = 2;

	// which channel holds the maximum, or a fixed hue
	localparam logic [1:0] SEL_RED   = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE  = 2'd2;
	localparam logic [1:0] SEL_FIXED = 2'd3;

	localparam int HUE_OFS_G = 120;
	localparam int HUE_OFS_B = 240;
	localparam int HUE_WRAP  = 360;

	typedef logic [CHAN_BITS-1:0] chan_t;
	typedef chan_t [NUM_CH-1:0]   chan_vec_t;
	typedef logic [DVD_BITS-1:0]  dvd_t;
	typedef dvd_t [NUM_CH-1:0]    dvd_vec_t;
	typedef logic [HUE_BITS-1:0]  hue_t;

	localparam hue_t HUE_GREY = hue_t'(300);
	localparam hue_t HUE_RG   = hue_t'(60);
	localparam hue_t HUE_RB   = hue_t'(300);
	localparam hue_t HUE_GB   = hue_t'(180);

	typedef struct packed {
		logic [1:0] sel;
		hue_t       fix_hue;
	} pix_ctl_t;

endpackage

### src/rgb_to_hue_integer_top.sv
// top level of the rgb to integer hue pipeline
//
// pixel channel: pix_valid/pix_ready with red, green, blue (unsigned channels);
// a beat is taken on a rising edge with pix_valid and pix_ready both high
// hue channel: hue_valid/hue_ready with hue in whole degrees, 0..359;
// grey pixels report 300, ties for the maximum give 60, 180 or 300
//
// path: a register after max/min/delta, one divider stage per quotient bit
// of the channel*60/delta divider (CHAN_BITS + 6 stages), then the output
// register that holds the formed and wrapped hue
// throughput is one pixel per clock while the receiver takes hues; the
// divider is fully pipelined; the single shared stage enable alone sets the rate
//
// reset clears only the valid bits of every stage, so the pipe comes up empty
// and hue_valid is low; pix_ready is high right after reset
// when the receiver stalls with a hue waiting, the whole pipe freezes and
// pix_ready drops; beats in flight are held, none lost or repeated; empty
// output register lets the pipe move, so bubbles drain while stalled
module rgb_to_hue_integer_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pix_valid,
	output logic            pix_ready,
	input  rgbh_pkg::chan_t red,
	input  rgbh_pkg::chan_t green,
	input  rgbh_pkg::chan_t blue,
	output logic            hue_valid,
	input  logic            hue_ready,
	output rgbh_pkg::hue_t  hue
);
	import rgbh_pkg::*;

	// pipe advance: output register free or being taken this cycle
	logic     adv;

	logic     valid_s1;
	dvd_vec_t dvd_s1;
	chan_t    delta_s1;
	pix_ctl_t ctl_s1;

	logic     quot_valid;
	dvd_vec_t quot;
	pix_ctl_t quot_ctl;

	assign adv       = !hue_valid || hue_ready;
	assign pix_ready = adv;

	// max/min/delta, case select and dividends
	rgbh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid    (pix_valid),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.valid_s1 (valid_s1),
		.dvd_s1   (dvd_s1),
		.delta_s1 (delta_s1),
		.ctl_s1   (ctl_s1)
	);

	// three scaled channels, one quotient bit per stage
	rgbh_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.valid      (valid_s1),
		.dvd        (dvd_s1),
		.delta      (delta_s1),
		.ctl        (ctl_s1),
		.quot_valid (quot_valid),
		.quot       (quot),
		.quot_ctl   (quot_ctl)
	);

	// hue select, wrap, output register
	rgbh_hue u_hue (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.valid       (quot_valid),
		.quot        (quot),
		.ctl         (quot_ctl),
		.hue_valid_q (hue_valid),
		.hue_q       (hue)
	);

`ifndef SYNTHESIS
	// hue always lands inside one turn
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hue_valid |-> (hue < hue_t'(HUE_WRAP)))
		else $error("hue out of range");

	// a waiting hue blocks new pixels
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(hue_valid && !hue_ready) |-> !pix_ready)
		else $error("pixel taken while output stalled");

	// empty output register never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!hue_valid |-> pix_ready)
		else $error("pipe stalled with empty output");

	// a stalled hue keeps its value into the next cycle
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(hue_valid && !hue_ready) |=> (hue_valid && $stable(hue)))
		else $error("stalled hue changed");
`endif

endmodule

### src/rgbh_front.sv
// first stage: max, min, delta, hue case and scaled dividends
module rgbh_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid,
	input  rgbh_pkg::chan_t    red,
	input  rgbh_pkg::chan_t    green,
	input  rgbh_pkg::chan_t    blue,
	output logic               valid_s1,
	output rgbh_pkg::dvd_vec_t dvd_s1,
	output rgbh_pkg::chan_t    delta_s1,
	output rgbh_pkg::pix_ctl_t ctl_s1
);
	import rgbh_pkg::*;

	chan_t    mx;
	chan_t    mn;
	chan_t    delta;
	pix_ctl_t ctl;
	dvd_vec_t dvd;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		delta = mx - mn;

		ctl.sel     = SEL_FIXED;
		ctl.fix_hue = HUE_GREY;
		priority if (delta == '0) begin
			ctl.sel     = SEL_FIXED;
			ctl.fix_hue = HUE_GREY;
		end else if (red > green && red > blue) begin
			ctl.sel = SEL_RED;
		end else if (green > red && green > blue) begin
			ctl.sel = SEL_GREEN;
		end else if (blue > red && blue > green) begin
			ctl.sel = SEL_BLUE;
		end else if (red == green) begin
			ctl.fix_hue = HUE_RG;
		end else if (red == blue) begin
			ctl.fix_hue = HUE_RB;
		end else begin
			ctl.fix_hue = HUE_GB;
		end

		// channel * 60, exact in the dividend width
		dvd[CH_R] = dvd_t'(red) * dvd_t'(SCALE);
		dvd[CH_G] = dvd_t'(green) * dvd_t'(SCALE);
		dvd[CH_B] = dvd_t'(blue) * dvd_t'(SCALE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s1   <= dvd;
			delta_s1 <= delta;
			ctl_s1   <= ctl;
		end
	end

endmodule

### src/rgbh_div.sv
// pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage
module rgbh_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid,
	input  rgbh_pkg::dvd_vec_t dvd,
	input  rgbh_pkg::chan_t    delta,
	input  rgbh_pkg::pix_ctl_t ctl,
	output logic               quot_valid,
	output rgbh_pkg::dvd_vec_t quot,
	output rgbh_pkg::pix_ctl_t quot_ctl
);
	import rgbh_pkg::*;

	localparam int NSTG = DVD_BITS;

	logic      v_q   [NSTG];
	dvd_vec_t  dvd_q [NSTG];
	dvd_vec_t  quo_q [NSTG];
	chan_vec_t rem_q [NSTG];
	chan_t     d_q   [NSTG];
	pix_ctl_t  ctl_q [NSTG];

	dvd_vec_t  quo_n [NSTG];
	chan_vec_t rem_n [NSTG];

	// one restoring step: returns quotient bit and new remainder
	function automatic logic [CHAN_BITS:0] div_step(chan_t rem, logic nb, chan_t d);
		logic [CHAN_BITS:0] trial;
		logic [CHAN_BITS:0] diff;
		trial = {rem, nb};
		diff  = trial - {1'b0, d};
		if (trial >= {1'b0, d}) return {1'b1, diff[CHAN_BITS-1:0]};
		return {1'b0, trial[CHAN_BITS-1:0]};
	endfunction

	always_comb begin
		logic [CHAN_BITS:0] st;
		for (int j = 0; j < NUM_CH; j++) begin
			st          = div_step('0, dvd[j][NSTG-1], delta);
			rem_n[0][j] = st[CHAN_BITS-1:0];
			quo_n[0][j] = {{(NSTG-1){1'b0}}, st[CHAN_BITS]};
			for (int k = 1; k < NSTG; k++) begin
				st          = div_step(rem_q[k-1][j], dvd_q[k-1][j][NSTG-1-k], d_q[k-1]);
				rem_n[k][j] = st[CHAN_BITS-1:0];
				quo_n[k][j] = {quo_q[k-1][j][NSTG-2:0], st[CHAN_BITS]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSTG; k++) v_q[k] <= 1'b0;
		end else if (en) begin
			v_q[0] <= valid;
			for (int k = 1; k < NSTG; k++) v_q[k] <= v_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_q[0] <= dvd;
			d_q[0]   <= delta;
			ctl_q[0] <= ctl;
			for (int k = 1; k < NSTG; k++) begin
				dvd_q[k] <= dvd_q[k-1];
				d_q[k]   <= d_q[k-1];
				ctl_q[k] <= ctl_q[k-1];
			end
			for (int k = 0; k < NSTG; k++) begin
				rem_q[k] <= rem_n[k];
				quo_q[k] <= quo_n[k];
			end
		end
	end

	assign quot_valid = v_q[NSTG-1];
	assign quot       = quo_q[NSTG-1];
	assign quot_ctl   = ctl_q[NSTG-1];

endmodule

### src/rgbh_hue.sv
// last stage: combine scaled channels, wrap negative hues, output register
module rgbh_hue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid,
	input  rgbh_pkg::dvd_vec_t quot,
	input  rgbh_pkg::pix_ctl_t ctl,
	output logic               hue_valid_q,
	output rgbh_pkg::hue_t     hue_q
);
	import rgbh_pkg::*;

	localparam int SW = DVD_BITS + 2;

	logic signed [SW-1:0] rs;
	logic signed [SW-1:0] gs;
	logic signed [SW-1:0] bs;
	logic signed [SW-1:0] h_raw;
	logic signed [SW-1:0] h_wrap;

	always_comb begin
		rs = signed'(SW'(quot[CH_R]));
		gs = signed'(SW'(quot[CH_G]));
		bs = signed'(SW'(quot[CH_B]));
		unique case (ctl.sel)
			SEL_RED:   h_raw = gs - bs;
			SEL_GREEN: h_raw = signed'(SW'(HUE_OFS_G)) + bs - rs;
			SEL_BLUE:  h_raw = signed'(SW'(HUE_OFS_B)) + rs - gs;
			SEL_FIXED: h_raw = signed'(SW'(ctl.fix_hue));
		endcase
		h_wrap = h_raw[SW-1] ? h_raw + signed'(SW'(HUE_WRAP)) : h_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_valid_q <= 1'b0;
		end else if (en) begin
			hue_valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= h_wrap[HUE_BITS-1:0];
		end
	end

endmodule
